[sv/dqne_pkg.sv]
// Shared types and constants of the DNS query name encoder.
`timescale 1ns / 1ps
package dqne_pkg;

    // One input beat: a name character or the end-of-name marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] character;
    } t_in_item;

    // One output beat: a single byte write into the question area.
    typedef struct packed {
        logic [8:0] write_address;
        logic [7:0] write_data;
        logic       write_valid;
        logic       run_last;
        logic [9:0] total_length;
        logic       overflow;
    } t_out_item;

    localparam logic       KIND_CHAR = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [7:0] DOT_CHAR  = 8'd46;

    localparam int unsigned HEADER_BYTES = 12;

    localparam logic       CFG_QUERY_TYPE  = 1'b0;
    localparam logic       CFG_QUERY_CLASS = 1'b1;

    localparam logic [15:0] QUERY_TYPE_RST  = 16'd1;
    localparam logic [15:0] QUERY_CLASS_RST = 16'd1;

    // Trailer bytes after the last label count; the value is the offset from
    // the write position at which the end beat arrived.
    typedef enum logic [2:0] {
        TRL_ROOT     = 3'd0,
        TRL_TYPE_HI  = 3'd1,
        TRL_TYPE_LO  = 3'd2,
        TRL_CLASS_HI = 3'd3,
        TRL_CLASS_LO = 3'd4
    } t_trl_step;

endpackage

[sv/dqne_byte_fmt.sv]
// Byte write formatter: saturate the offset, flag drops, build the output beat.
`timescale 1ns / 1ps
module dqne_byte_fmt #(
    parameter int unsigned POS_W = 10,
    parameter int unsigned QBUF  = 500
) (
    input  logic [POS_W-1:0]     i_addr,
    input  logic [7:0]           i_data,
    input  logic                 i_last,
    input  logic [POS_W-1:0]     i_total,
    input  logic                 i_ovf,
    output dqne_pkg::t_out_item  o_item,
    output logic                 o_ovf
);
    import dqne_pkg::*;

    logic [POS_W-1:0]  addr_sat;
    logic              in_buf;
    logic [POS_W+8:0]  addr_ext;
    logic [POS_W+9:0]  total_ext;

    always_comb begin
        in_buf    = (i_addr < POS_W'(QBUF));
        addr_sat  = (i_addr > POS_W'(QBUF)) ? POS_W'(QBUF) : i_addr;
        addr_ext  = {9'd0, addr_sat};
        total_ext = {10'd0, i_total};
        o_ovf     = i_ovf | ~in_buf;

        o_item.write_address = addr_ext[8:0];
        o_item.write_data    = i_data;
        o_item.write_valid   = in_buf;
        o_item.run_last      = i_last;
        o_item.total_length  = total_ext[9:0];
        o_item.overflow      = o_ovf;
    end

endmodule

[sv/dns_query_name_encoder.sv]
// Top level of the DNS query name encoder: name state, trailer sequencer, output register.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data): one beat per name
//   character, or an end beat that closes the name. Output channel
//   (o_out_valid / i_out_ready / o_out_data): one beat per byte write into
//   the question area, which starts after the header.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   writes the query type and class; always ready, write only while idle.
// Throughput
//   A character beat gives its write beat through the output register, and
//   a new character is taken in every cycle while the output register is
//   free and no trailer runs. An end beat gives six write beats; the trailer
//   sequencer owns the output register for the last five, so the input is held off while it runs.
//   The last beat of an end item carries the total message length.
// Reset
//   Synchronous, active low: type and class return to 1, the name state to
//   its start (first count byte at offset 0, first character at offset 1).
// Stalls
//   While the receiver holds i_out_ready low the output beat is kept and
//   o_in_ready falls; nothing is dropped or repeated.
module dns_query_name_encoder #(
    parameter int unsigned PACKET_BYTES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dqne_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dqne_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import dqne_pkg::*;

    localparam int unsigned QBUF  = PACKET_BYTES - HEADER_BYTES;
    localparam int unsigned POS_W = $clog2(PACKET_BYTES + 1);

    // Configuration registers
    logic [15:0]      r_qtype;
    logic [15:0]      r_qclass;

    // Name state
    logic [POS_W-1:0] r_wr_pos,  n_wr_pos;
    logic [POS_W-1:0] r_cnt_pos, n_cnt_pos;
    logic [7:0]       r_lbl_cnt, n_lbl_cnt;
    logic             r_ovf,     n_ovf;

    // Trailer sequencer
    logic             r_trl_busy, n_trl_busy;
    t_trl_step        r_trl_step, n_trl_step;
    logic [POS_W-1:0] r_trl_base, n_trl_base;

    // Output register
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out,       n_out;

    // Formatter hookup
    logic [POS_W-1:0] f_addr;
    logic [7:0]       f_data;
    logic             f_last;
    logic [POS_W-1:0] f_total;
    t_out_item        f_item;
    logic             f_ovf;

    logic             out_free;
    logic             in_acc;
    logic             trl_adv;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] base_end;

    dqne_byte_fmt #(
        .POS_W (POS_W),
        .QBUF  (QBUF)
    ) u_fmt (
        .i_addr  (f_addr),
        .i_data  (f_data),
        .i_last  (f_last),
        .i_total (f_total),
        .i_ovf   (r_ovf),
        .o_item  (f_item),
        .o_ovf   (f_ovf)
    );

    // The output register frees up when empty or when its beat is taken.
    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_in_ready  = out_free & ~r_trl_busy;
    assign in_acc      = i_in_valid & o_in_ready;
    assign trl_adv     = r_trl_busy & out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        pos_inc  = r_wr_pos + POS_W'(1);
        if (pos_inc > POS_W'(QBUF)) begin
            pos_inc = POS_W'(QBUF);
        end
        base_end = r_trl_base + POS_W'(TRL_CLASS_LO) + POS_W'(1);
        if (base_end > POS_W'(QBUF)) begin
            base_end = POS_W'(QBUF);
        end
    end

    always_comb begin
        n_wr_pos    = r_wr_pos;
        n_cnt_pos   = r_cnt_pos;
        n_lbl_cnt   = r_lbl_cnt;
        n_ovf       = r_ovf;
        n_trl_busy  = r_trl_busy;
        n_trl_step  = r_trl_step;
        n_trl_base  = r_trl_base;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        f_addr      = r_wr_pos;
        f_data      = i_in_data.character;
        f_last      = 1'b1;
        f_total     = '0;

        if (trl_adv) begin
            // Trailer beats: root byte, then type and class big-endian.
            f_addr = r_trl_base + POS_W'(r_trl_step);
            f_last = 1'b0;
            unique case (r_trl_step)
                TRL_ROOT: begin
                    f_data     = 8'd0;
                    n_trl_step = TRL_TYPE_HI;
                end
                TRL_TYPE_HI: begin
                    f_data     = r_qtype[15:8];
                    n_trl_step = TRL_TYPE_LO;
                end
                TRL_TYPE_LO: begin
                    f_data     = r_qtype[7:0];
                    n_trl_step = TRL_CLASS_HI;
                end
                TRL_CLASS_HI: begin
                    f_data     = r_qclass[15:8];
                    n_trl_step = TRL_CLASS_LO;
                end
                TRL_CLASS_LO: begin
                    f_data     = r_qclass[7:0];
                    f_last     = 1'b1;
                    f_total    = base_end + POS_W'(HEADER_BYTES);
                    n_trl_step = TRL_ROOT;
                end
                default: begin
                    f_data     = 8'd0;
                    n_trl_step = TRL_ROOT;
                end
            endcase
            n_out_valid = 1'b1;
            n_out       = f_item;
            // Name finished: drop the sticky overflow with the last beat.
            n_ovf       = f_last ? 1'b0 : f_ovf;
            n_trl_busy  = ~f_last;
        end else if (in_acc) begin
            n_out_valid = 1'b1;
            if (i_in_data.kind == KIND_END) begin
                // Patch the last count, then hand over to the trailer.
                f_addr     = r_cnt_pos;
                f_data     = r_lbl_cnt;
                f_last     = 1'b0;
                n_trl_busy = 1'b1;
                n_trl_step = TRL_ROOT;
                n_trl_base = r_wr_pos;
                n_wr_pos   = POS_W'(1);
                n_cnt_pos  = '0;
                n_lbl_cnt  = 8'd0;
            end else if (i_in_data.character == DOT_CHAR) begin
                // Patch the finished label count, reserve the next count byte.
                f_addr    = r_cnt_pos;
                f_data    = r_lbl_cnt;
                n_cnt_pos = r_wr_pos;
                n_lbl_cnt = 8'd0;
                n_wr_pos  = pos_inc;
            end else begin
                n_lbl_cnt = r_lbl_cnt + 8'd1;
                n_wr_pos  = pos_inc;
            end
            n_out = f_item;
            n_ovf = f_ovf;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtype     <= QUERY_TYPE_RST;
            r_qclass    <= QUERY_CLASS_RST;
            r_wr_pos    <= POS_W'(1);
            r_cnt_pos   <= '0;
            r_lbl_cnt   <= 8'd0;
            r_ovf       <= 1'b0;
            r_trl_busy  <= 1'b0;
            r_trl_step  <= TRL_ROOT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_QUERY_TYPE:  r_qtype  <= i_cfg_data;
                    CFG_QUERY_CLASS: r_qclass <= i_cfg_data;
                    default: ;
                endcase
            end
            r_wr_pos    <= n_wr_pos;
            r_cnt_pos   <= n_cnt_pos;
            r_lbl_cnt   <= n_lbl_cnt;
            r_ovf       <= n_ovf;
            r_trl_busy  <= n_trl_busy;
            r_trl_step  <= n_trl_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_trl_base <= n_trl_base;
        r_out      <= n_out;
    end

endmodule

[test/dns_query_name_encoder_tb.sv]
// Self-checking testbench of the DNS query name encoder: predictor, stimulus and write-beat checks.
`timescale 1ns / 1ps
module dns_query_name_encoder_tb;
    import dqne_pkg::*;

    localparam int unsigned PACKET_BYTES = 512;
    // Size of the question area; offsets at or past this are dropped.
    localparam int unsigned QBUF = PACKET_BYTES - HEADER_BYTES;

    // Clock, reset and every block input start at a known value.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = CFG_QUERY_TYPE;
    logic [15:0] cfg_data  = '0;

    logic        in_ready;
    logic        out_valid;
    t_out_item   out_data;
    logic        cfg_ready;

    // Stimulus shaping, shared between the sender and the receiver process.
    int          snd_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    int          hold_left     = 0;
    bit          offering      = 1'b0;
    int          mismatches    = 0;

    // Name encoder state as the predictor sees it.
    int unsigned wr_pos;
    int unsigned cnt_pos;
    logic [7:0]  lbl_len;
    bit          name_dropped;
    logic [15:0] q_type;
    logic [15:0] q_class;

    // Byte writes predicted but not yet seen, oldest first.
    t_out_item   expected_writes[$];

    always #4 clk = ~clk;

    dns_query_name_encoder #(
        .PACKET_BYTES(PACKET_BYTES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate a position at the end of the question area.
    function automatic int unsigned clip(int unsigned p);
        return (p > QBUF) ? QBUF : p;
    endfunction

    // Queue one predicted byte write; a write past the area is dropped and
    // latches the overflow flag for the rest of the name.
    function automatic void push_write(int unsigned addr, logic [7:0] data, bit last,
                                       int unsigned total);
        t_out_item w;
        if (addr >= QBUF)
            name_dropped = 1'b1;
        w.write_address = 9'(clip(addr));
        w.write_data    = data;
        w.write_valid   = (addr < QBUF);
        w.run_last      = last;
        w.total_length  = 10'(total);
        w.overflow      = name_dropped;
        expected_writes.push_back(w);
    endfunction

    function automatic void clear_name();
        wr_pos       = 1;
        cnt_pos      = 0;
        lbl_len      = '0;
        name_dropped = 1'b0;
    endfunction

    // Work out the byte writes that one accepted beat causes.
    function automatic void encode_beat(t_in_item it);
        int unsigned p;
        p = clip(wr_pos);
        if (it.kind == KIND_CHAR) begin
            if (it.character != DOT_CHAR) begin
                push_write(p, it.character, 1'b1, 0);
                lbl_len = lbl_len + 8'd1;
            end else begin
                // Back-patch the finished label and reserve the next count byte.
                push_write(clip(cnt_pos), lbl_len, 1'b1, 0);
                cnt_pos = p;
                lbl_len = '0;
            end
            wr_pos = clip(p + 1);
        end else begin
            // Last count, root byte, then type and class big-endian.
            push_write(clip(cnt_pos), lbl_len, 1'b0, 0);
            push_write(clip(p), 8'h00, 1'b0, 0);
            push_write(clip(p + 1), q_type[15:8], 1'b0, 0);
            push_write(clip(p + 2), q_type[7:0], 1'b0, 0);
            push_write(clip(p + 3), q_class[15:8], 1'b0, 0);
            push_write(clip(p + 4), q_class[7:0], 1'b1, clip(p + 5) + HEADER_BYTES);
            clear_name();
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: check each accepted write beat, then decide the next ready
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_writes.size() == 0) begin
                $display("%0t: write beat with nothing expected: addr=%0d data=%02h",
                         $time, out_data.write_address, out_data.write_data);
                mismatches++;
            end else if (out_data !== expected_writes[0]) begin
                $display("%0t: expected addr=%0d data=%02h vld=%0b last=%0b len=%0d ovf=%0b",
                         $time, expected_writes[0].write_address,
                         expected_writes[0].write_data, expected_writes[0].write_valid,
                         expected_writes[0].run_last, expected_writes[0].total_length,
                         expected_writes[0].overflow);
                $display("%0t: actual   addr=%0d data=%02h vld=%0b last=%0b len=%0d ovf=%0b",
                         $time, out_data.write_address, out_data.write_data,
                         out_data.write_valid, out_data.run_last, out_data.total_length,
                         out_data.overflow);
                mismatches++;
                void'(expected_writes.pop_front());
            end else begin
                void'(expected_writes.pop_front());
            end
        end
        // A requested hold-off overrides the random stalls until it runs out.
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one beat and hold it until accepted. Valid stays high into the
    // next call unless a gap is drawn, so back-to-back beats need one update.
    task automatic send_beat(logic kind, logic [7:0] ch);
        t_in_item it;
        it.kind      = kind;
        it.character = ch;
        if ($urandom_range(99) < snd_idle_pct) begin
            if (offering)
                in_valid <= 1'b0;
            offering = 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        offering = 1'b1;
        do @(posedge clk); while (!in_ready);
        encode_beat(it);
    endtask

    // Drop valid after the last beat of a stretch.
    task automatic in_drop();
        if (offering)
            in_valid <= 1'b0;
        offering = 1'b0;
    endtask

    // Wait until every predicted write has been seen.
    task automatic wait_drain();
        while (expected_writes.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back, only while the block is idle.
    task automatic set_query(logic [15:0] qt, logic [15:0] qc);
        in_drop();
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_QUERY_TYPE;
        cfg_data  <= qt;
        do @(posedge clk); while (!cfg_ready);
        q_type = qt;
        cfg_index <= CFG_QUERY_CLASS;
        cfg_data  <= qc;
        do @(posedge clk); while (!cfg_ready);
        q_class = qc;
        cfg_valid <= 1'b0;
    endtask

    // Random label byte that is never the separator.
    function automatic logic [7:0] label_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == DOT_CHAR) ? 8'h2D : c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the character byte, empty name, empty, leading and trailing
    // labels, and an end beat with a non-zero character.
    task automatic test_directed();
        send_beat(KIND_END, 8'h00);
        send_beat(KIND_CHAR, 8'h00);
        send_beat(KIND_CHAR, 8'hFF);
        send_beat(KIND_CHAR, 8'h7F);
        send_beat(KIND_CHAR, 8'h80);
        send_beat(KIND_CHAR, DOT_CHAR);
        send_beat(KIND_CHAR, DOT_CHAR);
        send_beat(KIND_CHAR, 8'h41);
        send_beat(KIND_CHAR, 8'h2D);
        send_beat(KIND_CHAR, DOT_CHAR);
        send_beat(KIND_END, 8'hFF);
        send_beat(KIND_CHAR, DOT_CHAR);
        send_beat(KIND_CHAR, 8'h78);
        send_beat(KIND_END, DOT_CHAR);
        send_beat(KIND_CHAR, 8'h61);
        send_beat(KIND_CHAR, 8'h2E ^ 8'h01);
        send_beat(KIND_END, 8'h55);
        in_drop();
    endtask

    // Overrun the question area with a name whose first label is longer than
    // 255 bytes, so its count byte wraps; keep writing and put a separator on
    // the saturated position, then check that a short name starts clean again.
    task automatic test_buffer_overflow();
        for (int k = 0; k < 300; k++)
            send_beat(KIND_CHAR, label_byte());
        send_beat(KIND_CHAR, DOT_CHAR);
        for (int k = 0; k < 205; k++)
            send_beat(KIND_CHAR, (k % 60 == 59) ? DOT_CHAR : label_byte());
        send_beat(KIND_CHAR, DOT_CHAR);
        send_beat(KIND_CHAR, 8'h63);
        send_beat(KIND_END, 8'h00);
        send_beat(KIND_CHAR, 8'h62);
        send_beat(KIND_END, 8'h00);
        in_drop();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the block fills and drops its input ready.
    task automatic test_backpressure();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_left     = 200;
        for (int k = 0; k < 40; k++) begin
            if (k % 13 == 12)
                send_beat(KIND_END, 8'h00);
            else
                send_beat(KIND_CHAR, (k % 5 == 4) ? DOT_CHAR : label_byte());
        end
        send_beat(KIND_END, 8'h00);
        in_drop();
    endtask

    // Mostly well-formed names with random content; the rest is noise and
    // names left open so they run into the next one.
    task automatic test_random_traffic(int snd, int rcv, logic [15:0] qt, logic [15:0] qc,
                                       int n_items);
        int sent;
        int r;
        int nlab;
        int len;
        set_query(qt, qc);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
                sent++;
            end else begin
                nlab = $urandom_range(1, 4);
                for (int l = 0; l < nlab; l++) begin
                    if (l != 0) begin
                        send_beat(KIND_CHAR, DOT_CHAR);
                        sent++;
                    end
                    len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                    for (int k = 0; k < len; k++) begin
                        send_beat(KIND_CHAR, label_byte());
                        sent++;
                    end
                end
                if ($urandom_range(9) == 0) begin
                    send_beat(KIND_CHAR, DOT_CHAR);
                    sent++;
                end
                // Leave a few names open.
                if (r >= 20) begin
                    send_beat(KIND_END, 8'($urandom_range(255)));
                    sent++;
                end
            end
        end
        in_drop();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // Predictor starts in the reset state: type A, class IN.
        q_type  = QUERY_TYPE_RST;
        q_class = QUERY_CLASS_RST;
        clear_name();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_buffer_overflow();
        test_backpressure();
        test_random_traffic(0, 0, 16'hFFFF, 16'hFFFF, 25);
        test_random_traffic(58, 0, 16'h0000, 16'h0000, 25);
        test_random_traffic(0, 58, 16'h8000, 16'($urandom_range(65535)), 25);
        test_random_traffic(12, 12, 16'($urandom_range(65535)), 16'h7FFF, 25);

        // Drain, then give anything stray time to show up.
        in_drop();
        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_writes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d write beats outstanding", $time,
                 expected_writes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
sv/dqne_pkg.sv
sv/dqne_byte_fmt.sv
sv/dns_query_name_encoder.sv
test/dns_query_name_encoder_tb.sv
